// ----- rtl/c_subset_tokenizer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_TOKENIZER_TOP_DEFINES_SVH
`define C_SUBSET_TOKENIZER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define CST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// Tokenizer package
// Transaction types, token kinds and scan modes.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int KIND_BITS     = 6;
    localparam int POSITION_BITS = 16;
    localparam int LENGTH_BITS   = 12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [KIND_BITS-1:0]     token_kind;
        logic [POSITION_BITS-1:0] start_line;
        logic [POSITION_BITS-1:0] start_column;
        logic [LENGTH_BITS-1:0]   token_length;
        logic                     last_of_run;
    } t_out;

    typedef enum logic [3:0] {
        M_START, M_IDENT, M_INT, M_FLOAT, M_STRING, M_STRESC,
        M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_OPER
    } t_mode;

    localparam logic [KIND_BITS-1:0] K_INT     = 6'd0;
    localparam logic [KIND_BITS-1:0] K_FLOAT   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_STRING  = 6'd2;
    localparam logic [KIND_BITS-1:0] K_KW0     = 6'd3;
    localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd12;
    localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd13;
    localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd14;
    localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd15;
    localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd16;
    localparam logic [KIND_BITS-1:0] K_LBRACK  = 6'd17;
    localparam logic [KIND_BITS-1:0] K_RBRACK  = 6'd18;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd19;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd20;
    localparam logic [KIND_BITS-1:0] K_DOT     = 6'd21;
    localparam logic [KIND_BITS-1:0] K_STAR    = 6'd24;
    localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd25;
    localparam logic [KIND_BITS-1:0] K_PCT     = 6'd26;
    localparam logic [KIND_BITS-1:0] K_CARET   = 6'd29;
    localparam logic [KIND_BITS-1:0] K_TILDE   = 6'd30;
    localparam logic [KIND_BITS-1:0] K_ARROW   = 6'd43;
    localparam logic [KIND_BITS-1:0] K_END     = 6'd44;
    localparam logic [KIND_BITS-1:0] K_UNKNOWN = 6'd45;

    // keywords packed right-aligned, with their lengths
    localparam logic [47:0] KW_TEXT [9] = '{
        48'h696e74, 48'h666c6f6174, 48'h766f6964, 48'h6966, 48'h656c7365,
        48'h7768696c65, 48'h666f72, 48'h72657475726e, 48'h636f6e7374
    };
    localparam logic [2:0] KW_LEN [9] = '{3'd3, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3,
                                          3'd6, 3'd5};

    // two-byte-capable operators: first byte, single kind, second byte, pair kind
    localparam logic [7:0]           OP_FIRST  [8] = '{"+", "-", "&", "|", "!", "=", "<", ">"};
    localparam logic [KIND_BITS-1:0] OP_SINGLE [8] = '{6'd22, 6'd23, 6'd27, 6'd28,
                                                       6'd31, 6'd32, 6'd33, 6'd34};
    localparam logic [7:0]           OP_SECOND [8] = '{"+", "-", "&", "|", "=", "=", "=", "="};
    localparam logic [KIND_BITS-1:0] OP_DOUBLE [8] = '{6'd41, 6'd42, 6'd39, 6'd40,
                                                       6'd36, 6'd35, 6'd37, 6'd38};

    function automatic logic f_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic f_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

endpackage

// ----- rtl/c_subset_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// C subset tokenizer
// Streaming lexer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in) carries one source byte or an
//   end-of-input marker per transaction. Output channel (o_out_valid/
//   i_out_ready, o_out) carries one token per transaction; last_of_run marks
//   the final token caused by a given input transaction.
//   Scan state is updated in the cycle a byte is accepted; the tokens it
//   produces land in a two-entry output buffer and appear on o_out the next
//   cycle. Throughput is one byte per cycle while each byte yields at most one
//   token and the receiver is ready. A byte that closes a pending token and
//   also forms one itself fills both buffer slots; input then stalls while
//   the first of the two drains.
//   A stalled receiver holds o_out steady; input is taken only when the
//   buffer will have room for the worst case of two tokens.
//   Reset: scan mode start, line/column 1, buffer empty.
//   End of input flushes any pending token, emits the end token and restarts
//   at line 1, column 1.
// ----------------------------------------------------------------------------
`include "c_subset_tokenizer_top_defines.svh"

module c_subset_tokenizer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  cst_pkg::t_in i_in,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output cst_pkg::t_out o_out
);
    import cst_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // scan state
    t_mode                   r_mode, n_mode;
    logic [2:0]              r_op, n_op;
    logic [POSITION_BITS-1:0] r_line, n_line, r_col, n_col, r_tline, n_tline;
    logic [POSITION_BITS-1:0] r_tcol, n_tcol;
    logic [LENGTH_BITS-1:0]  r_cnt, n_cnt;
    logic [47:0]             r_win, n_win;

    // output buffer: two slots
    t_out       r_buf [2];
    logic [1:0] r_fill;

    // tokens produced by the current byte
    t_out       w_tok [2];
    logic [1:0] w_ntok;

    logic w_acc, w_pop;
    assign w_pop      = o_out_valid && i_out_ready;
    assign o_in_ready = (r_fill == 2'd0) || (r_fill == 2'd1 && w_pop);
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_fill != 2'd0;
    assign o_out       = r_buf[0];

    function automatic t_out f_tok(input logic [KIND_BITS-1:0] k,
                                   input logic [POSITION_BITS-1:0] l,
                                   input logic [POSITION_BITS-1:0] c,
                                   input logic [LENGTH_BITS-1:0] n);
        t_out t;
        t.token_kind   = k;
        t.start_line   = l;
        t.start_column = c;
        t.token_length = n;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // keyword match on the packed window
    logic [KIND_BITS-1:0] w_ident_kind;
    always_comb begin
        w_ident_kind = K_IDENT;
        for (int k = 8; k >= 0; k--) begin
            if (r_cnt == LENGTH_BITS'(KW_LEN[k]) && r_win == KW_TEXT[k])
                w_ident_kind = K_KW0 + KIND_BITS'(k);
        end
    end

    logic [7:0] b;
    logic       w_start;
    logic [KIND_BITS-1:0] w_single;
    logic       w_single_hit, w_op_hit, w_blank;
    logic [2:0] w_op_idx;

    assign b = i_in.data_byte;

    // classification of the byte for the start mode
    always_comb begin
        w_op_hit = 1'b0;
        w_op_idx = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (b == OP_FIRST[k]) begin
                w_op_hit = 1'b1;
                w_op_idx = 3'(k);
            end
        end
        w_blank = b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a;
        case (b)
            "(":     w_single = K_LPAREN;
            ")":     w_single = K_RPAREN;
            "{":     w_single = K_LBRACE;
            "}":     w_single = K_RBRACE;
            "[":     w_single = K_LBRACK;
            "]":     w_single = K_RBRACK;
            ";":     w_single = K_SEMI;
            ",":     w_single = K_COMMA;
            ".":     w_single = K_DOT;
            "*":     w_single = K_STAR;
            "%":     w_single = K_PCT;
            "^":     w_single = K_CARET;
            "~":     w_single = K_TILDE;
            default: w_single = K_UNKNOWN;
        endcase
        w_single_hit = !w_blank && !f_alpha(b) && !f_digit(b) && b != "\"" && b != "/"
                       && !w_op_hit;
    end

    always_comb begin
        logic [LENGTH_BITS-1:0] grow_cnt;
        grow_cnt = (r_cnt < LEN_MAX) ? r_cnt + LENGTH_BITS'(1) : r_cnt;
        n_mode  = r_mode;
        n_op    = r_op;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_cnt   = r_cnt;
        n_win   = r_win;
        w_ntok  = 2'd0;
        w_tok[0] = f_tok(K_END, r_line, r_col, '0);
        w_tok[1] = f_tok(K_END, r_line, r_col, '0);
        w_start = 1'b0;

        if (i_in.end_of_input) begin
            unique case (r_mode)
                M_IDENT:  begin w_tok[0] = f_tok(w_ident_kind, r_tline, r_tcol, r_cnt);
                                w_ntok = 2'd1; end
                M_INT:    begin w_tok[0] = f_tok(K_INT, r_tline, r_tcol, r_cnt);
                                w_ntok = 2'd1; end
                M_FLOAT:  begin w_tok[0] = f_tok(K_FLOAT, r_tline, r_tcol, r_cnt);
                                w_ntok = 2'd1; end
                M_STRING, M_STRESC: begin
                    w_tok[0] = f_tok(K_STRING, r_tline, r_tcol, r_cnt);
                    w_ntok = 2'd1;
                end
                M_SLASH:  begin w_tok[0] = f_tok(K_SLASH, r_tline, r_tcol, LENGTH_BITS'(1));
                                w_ntok = 2'd1; end
                M_OPER:   begin w_tok[0] = f_tok(OP_SINGLE[r_op], r_tline, r_tcol,
                                                 LENGTH_BITS'(1));
                                w_ntok = 2'd1; end
                default:  w_ntok = 2'd0;
            endcase
            w_tok[w_ntok[0]] = f_tok(K_END, r_line, r_col, '0);
            w_ntok = w_ntok + 2'd1;
            n_mode = M_START; n_op = '0; n_line = POS_ONE; n_col = POS_ONE;
            n_tline = POS_ONE; n_tcol = POS_ONE; n_cnt = '0; n_win = '0;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (f_alpha(b) || f_digit(b)) begin
                        n_cnt = grow_cnt; n_win = {r_win[39:0], b};
                    end else begin
                        w_tok[0] = f_tok(w_ident_kind, r_tline, r_tcol, r_cnt);
                        w_ntok = 2'd1; w_start = 1'b1;
                    end
                end
                M_INT: begin
                    if (f_digit(b) || b == ".") begin
                        n_cnt = grow_cnt; n_win = {r_win[39:0], b};
                        if (b == ".") n_mode = M_FLOAT;
                    end else begin
                        w_tok[0] = f_tok(K_INT, r_tline, r_tcol, r_cnt);
                        w_ntok = 2'd1; w_start = 1'b1;
                    end
                end
                M_FLOAT: begin
                    if (f_digit(b)) begin
                        n_cnt = grow_cnt; n_win = {r_win[39:0], b};
                    end else begin
                        w_tok[0] = f_tok(K_FLOAT, r_tline, r_tcol, r_cnt);
                        w_ntok = 2'd1; w_start = 1'b1;
                    end
                end
                M_STRING: begin
                    n_cnt = grow_cnt; n_win = {r_win[39:0], b};
                    if (b == "\\") n_mode = M_STRESC;
                    else if (b == "\"") begin
                        w_tok[0] = f_tok(K_STRING, r_tline, r_tcol, grow_cnt);
                        w_ntok = 2'd1; n_mode = M_START;
                    end
                end
                M_STRESC: begin
                    n_cnt = grow_cnt; n_win = {r_win[39:0], b}; n_mode = M_STRING;
                end
                M_SLASH: begin
                    if (b == "/") n_mode = M_LINE;
                    else if (b == "*") n_mode = M_BLOCK;
                    else begin
                        w_tok[0] = f_tok(K_SLASH, r_tline, r_tcol, LENGTH_BITS'(1));
                        w_ntok = 2'd1; w_start = 1'b1;
                    end
                end
                M_LINE:  if (b == 8'h0a) n_mode = M_START;
                M_BLOCK: if (b == "*") n_mode = M_BSTAR;
                M_BSTAR: begin
                    if (b == "/") n_mode = M_START;
                    else if (b != "*") n_mode = M_BLOCK;
                end
                M_OPER: begin
                    if (b == OP_SECOND[r_op]) begin
                        w_tok[0] = f_tok(OP_DOUBLE[r_op], r_tline, r_tcol, LENGTH_BITS'(2));
                        w_ntok = 2'd1; n_mode = M_START;
                    end else if (r_op == 3'd1 && b == ">") begin
                        w_tok[0] = f_tok(K_ARROW, r_tline, r_tcol, LENGTH_BITS'(2));
                        w_ntok = 2'd1; n_mode = M_START;
                    end else begin
                        w_tok[0] = f_tok(OP_SINGLE[r_op], r_tline, r_tcol, LENGTH_BITS'(1));
                        w_ntok = 2'd1; w_start = 1'b1;
                    end
                end
                default: w_start = 1'b1;
            endcase

            // start-mode handling of the current byte
            if (w_start) begin
                n_mode = M_START;
                if (!w_blank) begin
                    if (w_single_hit) begin
                        w_tok[w_ntok[0]] = f_tok(w_single, r_line, r_col, LENGTH_BITS'(1));
                        w_ntok = w_ntok + 2'd1;
                    end else begin
                        n_tline = r_line; n_tcol = r_col;
                        n_cnt = LENGTH_BITS'(1); n_win = {40'd0, b};
                        if (f_alpha(b))      n_mode = M_IDENT;
                        else if (f_digit(b)) n_mode = M_INT;
                        else if (b == "\"")  n_mode = M_STRING;
                        else if (b == "/")   n_mode = M_SLASH;
                        else begin
                            n_mode = M_OPER; n_op = w_op_idx;
                        end
                    end
                end
            end

            if (b == 8'h0a) begin
                if (r_line < POS_MAX) n_line = r_line + POS_ONE;
                n_col = POS_ONE;
            end else if (r_col < POS_MAX) begin
                n_col = r_col + POS_ONE;
            end
        end

        if (w_ntok == 2'd1) w_tok[0].last_of_run = 1'b1;
        if (w_ntok == 2'd2) w_tok[1].last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_START;
            r_op    <= '0;
            r_line  <= POS_ONE;
            r_col   <= POS_ONE;
            r_tline <= POS_ONE;
            r_tcol  <= POS_ONE;
            r_cnt   <= '0;
            r_win   <= '0;
        end else if (w_acc) begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_cnt   <= n_cnt;
            r_win   <= n_win;
        end
    end

    // buffer fill count: less one for a pop, plus the tokens of an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= r_fill - {1'b0, w_pop} + (w_acc ? w_ntok : 2'd0);
        end
    end

    // input is taken only when nothing remains after the pop
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_buf[0] <= w_tok[0];
            r_buf[1] <= w_tok[1];
        end else if (w_pop) begin
            r_buf[0] <= r_buf[1];
        end
    end

    `CST_ASSERT_IMPL(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill != 2'd3,
                     "output buffer overfilled")
    `CST_ASSERT_IMPL(a_eoi_emits, i_clk, i_rst_n, w_acc && i_in.end_of_input,
                     w_ntok != 2'd0, "end of input produced no token")
    `CST_ASSERT_NEXT(a_eoi_restart, i_clk, i_rst_n, w_acc && i_in.end_of_input,
                     r_mode == M_START && r_line == POS_ONE,
                     "scanner did not restart after end of input")

endmodule
